FILE: design/life_automaton_row_step_macros.svh
// Assertion shorthands for the row step checker
`ifndef LIFE_AUTOMATON_ROW_STEP_MACROS_SVH
`define LIFE_AUTOMATON_ROW_STEP_MACROS_SVH

`define LARS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define LARS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/lars_pkg.sv
package lars_pkg;

  localparam int ROW_BITS    = 64;
  localparam int WIDTH_BITS  = 7;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 2;
  localparam int COUNT_BITS  = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = 2;
  localparam int QCNT_BITS   = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_WIDTH = 2'd0;
  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET      = 7'd64;

  localparam logic [COUNT_BITS-1:0] BIRTH_COUNT   = 4'd3;
  localparam logic [COUNT_BITS-1:0] SURVIVE_COUNT = 4'd2;

  typedef struct packed {
    logic [ROW_BITS-1:0] row_cells;
    logic                frame_last_row;
  } lars_in_t;

  typedef struct packed {
    logic [ROW_BITS-1:0] next_row;
    logic                frame_done;
  } lars_out_t;

  typedef struct packed {
    logic push_a;
    logic push_b;
    logic pop;
  } lars_q_ctrl_t;

  typedef struct packed {
    logic not_empty;
    logic low_room;
  } lars_q_status_t;

endpackage

FILE: design/lars_lane.sv
module lars_lane
  import lars_pkg::*;
(
  input  logic [7:0] nbr,
  input  logic       alive,
  input  logic       en,
  output logic       next
);

  logic [COUNT_BITS-1:0] cnt;

  always_comb begin
    cnt  = COUNT_BITS'($countones(nbr));
    next = en & ((cnt == BIRTH_COUNT) | (alive & (cnt == SURVIVE_COUNT)));
  end

endmodule

FILE: design/lars_evolve.sv
module lars_evolve
  import lars_pkg::*;
#(
  parameter int N = 64
) (
  input  logic [WIDTH_BITS-1:0] width,
  input  logic [N-1:0]          above,
  input  logic [N-1:0]          here,
  input  logic [N-1:0]          below,
  output logic [N-1:0]          next
);

  logic [N-1:0] en;
  logic [N+1:0] ext_a;
  logic [N+1:0] ext_h;
  logic [N+1:0] ext_b;

  for (genvar c = 0; c < N; c++) begin : g_en
    assign en[c] = (width > WIDTH_BITS'(c));
  end

  assign ext_a = {1'b0, above & en, 1'b0};
  assign ext_h = {1'b0, here & en, 1'b0};
  assign ext_b = {1'b0, below & en, 1'b0};

  for (genvar c = 0; c < N; c++) begin : g_lane
    lars_lane u_lane (
      .nbr   ({ext_a[c+2:c], ext_b[c+2:c], ext_h[c+2], ext_h[c]}),
      .alive (ext_h[c+1]),
      .en    (en[c]),
      .next  (next[c])
    );
  end

endmodule

FILE: design/lars_queue.sv
module lars_queue
  import lars_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  lars_q_ctrl_t   ctrl,
  input  lars_out_t      wr_a,
  input  lars_out_t      wr_b,
  output lars_out_t      head,
  output lars_q_status_t status
);

  lars_out_t              mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [QPTR_BITS-1:0]   b_ptr;

  always_comb begin
    b_ptr      = wr_ptr_r + QPTR_BITS'(ctrl.push_a);
    wr_ptr_nxt = b_ptr + QPTR_BITS'(ctrl.push_b);
    rd_ptr_nxt = rd_ptr_r + QPTR_BITS'(ctrl.pop);
    cnt_nxt    = cnt_r + QCNT_BITS'(ctrl.push_a) + QCNT_BITS'(ctrl.push_b)
                 - QCNT_BITS'(ctrl.pop);
  end

  always_ff @(posedge clk) begin
    if (ctrl.push_a) begin
      mem[wr_ptr_r] <= wr_a;
    end
    if (ctrl.push_b) begin
      mem[b_ptr] <= wr_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign head             = mem[rd_ptr_r];
  assign status.not_empty = (cnt_r != '0);
  assign status.low_room  = (cnt_r >= QCNT_BITS'(QUEUE_DEPTH - 1));

endmodule

FILE: design/life_automaton_row_step.sv
// One generation of the B3/S23 life automaton, one frame row per request.
// Input channel in_*: a row of cells (bit c is column c) and a flag for the
// bottom row of the frame. Output channel out_*: next-generation rows, the
// bottom one of each frame marked with frame_done.
// Register active_width (byte address 0 of the APB port) sets the columns in
// use; higher columns are dead and read back as zero. Write it while idle.
// The first row of a frame gives no result; each later row gives the result
// for the row above it; a flagged row also gives the result for itself.
// A result enters the result queue as its row is accepted; out_* shows the head.
// Throughput: one row per cycle while in_stall is low; two sets of ROW_CELLS rule
// lanes evaluate a whole row at once, and a flagged row writes two results into
// the four-entry result queue in the same cycle.
// in_stall rises when the result queue has fewer than two free entries, so a
// stalled receiver backs up the input once three results are queued.
// Reset clears the held rows, empties the queue and sets active_width to 64.
module life_automaton_row_step
  import lars_pkg::*;
#(
  parameter int ROW_CELLS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  lars_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lars_out_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [WIDTH_BITS-1:0] width_r, width_nxt;
  logic [ROW_CELLS-1:0]  upper_r, upper_nxt;
  logic [ROW_CELLS-1:0]  middle_r, middle_nxt;
  logic                  held_r, held_nxt;

  logic                  accept;
  logic [ROW_CELLS-1:0]  row;
  logic [ROW_CELLS-1:0]  res_a, res_b;
  lars_out_t             wr_a, wr_b;
  lars_q_ctrl_t          q_ctrl;
  lars_q_status_t        q_status;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_ACTIVE_WIDTH) ?
                  {{(CFG_DATA_W-WIDTH_BITS){1'b0}}, width_r} : '0;

  assign in_stall = q_status.low_room;
  assign accept   = in_valid & ~in_stall;
  assign row      = in_data.row_cells[ROW_CELLS-1:0];

  always_comb begin
    width_nxt = width_r;
    if (psel && penable && pwrite && pready && (paddr == REG_ACTIVE_WIDTH)) begin
      width_nxt = pwdata[WIDTH_BITS-1:0];
    end
  end

  always_comb begin
    upper_nxt  = upper_r;
    middle_nxt = middle_r;
    held_nxt   = held_r;
    if (accept) begin
      if (in_data.frame_last_row) begin
        upper_nxt  = '0;
        middle_nxt = '0;
        held_nxt   = 1'b0;
      end else begin
        upper_nxt  = middle_r;
        middle_nxt = row;
        held_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      upper_r  <= '0;
      middle_r <= '0;
      held_r   <= 1'b0;
    end else begin
      width_r  <= width_nxt;
      upper_r  <= upper_nxt;
      middle_r <= middle_nxt;
      held_r   <= held_nxt;
    end
  end

  lars_evolve #(.N(ROW_CELLS)) u_evolve_a (
    .width (width_r),
    .above (upper_r),
    .here  (middle_r),
    .below (row),
    .next  (res_a)
  );

  lars_evolve #(.N(ROW_CELLS)) u_evolve_b (
    .width (width_r),
    .above (held_r ? middle_r : '0),
    .here  (row),
    .below ('0),
    .next  (res_b)
  );

  always_comb begin
    wr_a                              = '0;
    wr_a.next_row[ROW_CELLS-1:0]      = res_a;
    wr_a.frame_done                   = 1'b0;
    wr_b                              = '0;
    wr_b.next_row[ROW_CELLS-1:0]      = res_b;
    wr_b.frame_done                   = 1'b1;
  end

  assign q_ctrl.push_a = accept & held_r;
  assign q_ctrl.push_b = accept & in_data.frame_last_row;
  assign q_ctrl.pop    = out_valid & ~out_stall;

  lars_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (q_ctrl),
    .wr_a   (wr_a),
    .wr_b   (wr_b),
    .head   (out_data),
    .status (q_status)
  );

  assign out_valid = q_status.not_empty;

endmodule

FILE: design/lars_checker.sv
`include "life_automaton_row_step_macros.svh"

module lars_checker
  import lars_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input lars_in_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input lars_out_t out_data
);

  `LARS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  `LARS_ASSERT_NEXT(a_flag_result, in_valid && !in_stall && in_data.frame_last_row, out_valid, "flagged row gave no result")

  `LARS_ASSERT_SAME(a_empty_ready, !out_valid, !in_stall, "input stalled with no result pending")

endmodule

bind life_automaton_row_step lars_checker u_lars_checker (.*);
